### hw/rtl/etmf_pkg.sv
// Shared constants and helpers for the encoder speed trimmed-mean filter.
// No dependencies; imported by the top level and the divider.

package etmf_pkg;

  // Fixed-point scales of the speed factor and the filter weight
  localparam int unsigned SCALE_FRAC = 16;
  localparam logic [16:0] ONE_Q16    = 17'd65536;

  // Register widths
  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned KEEP_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_KEEP   = 2'd2;

  typedef logic signed [31:0] speed_t;

  // Divider handshake
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } div_rsp_t;

  // Clamp a wide signed value into 32 bits
  function automatic speed_t sat32(input logic signed [63:0] v);
    speed_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/etmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the sample window.

module etmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/etmf_div.sv
// Constant-divisor unsigned divider by reciprocal multiplication, four partial products.
// Depends on etmf_pkg for the request and response structs.

module etmf_div import etmf_pkg::*; #(
  parameter int DIVIDEND_W = 36,
  parameter int DIVISOR    = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  div_req_t              req,
  input  logic [DIVIDEND_W-1:0] dividend,
  output div_rsp_t              rsp,
  output logic [DIVIDEND_W-1:0] quotient
);

  // floor(x * RECIP / 2^RSH) equals floor(x / DIVISOR) for every x below 2^DIVIDEND_W
  localparam int RSH  = DIVIDEND_W + $clog2(DIVISOR);
  localparam int MW   = DIVIDEND_W + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RSH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

  // Operand halves and accumulator sizes
  localparam int XL_W  = DIVIDEND_W / 2;
  localparam int XH_W  = DIVIDEND_W - XL_W;
  localparam int ML_W  = MW / 2;
  localparam int MH_W  = MW - ML_W;
  localparam int PP_W  = XH_W + MH_W;
  localparam int ACC_W = DIVIDEND_W + MW;

  logic                  busy;
  logic                  done;
  logic [1:0]            step;
  logic [DIVIDEND_W-1:0] x;
  logic [ACC_W-1:0]      acc;
  logic [XH_W-1:0]       op_x;
  logic [MH_W-1:0]       op_m;
  logic [PP_W-1:0]       pp;
  logic [ACC_W-1:0]      pp_sh;

  // Pick one half of each operand per step
  assign op_x = step[1] ? x[DIVIDEND_W-1:XL_W] : XH_W'(x[XL_W-1:0]);
  assign op_m = step[0] ? RECIP[MW-1:ML_W] : MH_W'(RECIP[ML_W-1:0]);
  assign pp   = PP_W'(op_x) * PP_W'(op_m);

  // Align the partial product to its weight
  always_comb begin
    case (step)
      2'd0:    pp_sh = ACC_W'(pp);
      2'd1:    pp_sh = ACC_W'(pp) << ML_W;
      2'd2:    pp_sh = ACC_W'(pp) << XL_W;
      default: pp_sh = ACC_W'(pp) << (XL_W + ML_W);
    endcase
  end

  // Control: one partial product per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: capture the dividend, accumulate the product
  always_ff @(posedge clk) begin
    if (req.start) begin
      x   <= dividend;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + pp_sh;
    end
  end

  assign quotient = acc[RSH +: DIVIDEND_W];
  assign rsp.done = done;
  assign rsp.busy = busy;

endmodule

### hw/rtl/encoder_speed_trimmed_mean_filter.sv
// Encoder speed estimator: scaled position deltas, trimmed mean of a window, low-pass.
// Depends on etmf_pkg, etmf_ram (sample window) and etmf_div (mean divider).
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in      | in        | in_valid / in_ready   | encoder_position
//   out     | out       | out_valid / out_ready | filtered_speed
//
// A tick that takes no sample is accepted straight from idle. A sample tick scales the
// position delta (S_MUL, S_RND), then moves past larger window entries one by one in the
// sorted-insert loop (S_INS). The tick that fills the window adds the trimmed sum of the
// kept entries, the mean by reciprocal multiply, and the filter blend and output load.
// The window RAM port and the multiplier are shared resources.
// Reset is synchronous; no clearing pass. A stalled output holds only the final load.

module encoder_speed_trimmed_mean_filter import etmf_pkg::*; #(
  parameter int WINDOW_SIZE     = 10,
  parameter int TRIM_EACH_SIDE  = 2,
  parameter int SPEED_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    encoder_position,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    filtered_speed
);

  // Derived sizes
  localparam int AW      = $clog2(WINDOW_SIZE);
  localparam int TRIM    = (TRIM_EACH_SIDE > (WINDOW_SIZE - 1) / 2) ?
                           (WINDOW_SIZE - 1) / 2 : TRIM_EACH_SIDE;
  localparam int KEPT    = WINDOW_SIZE - 2 * TRIM;
  localparam int LO      = TRIM;
  localparam int HI      = WINDOW_SIZE - TRIM - 1;
  localparam int SUM_W   = 32 + $clog2(WINDOW_SIZE);
  localparam int PROD_W  = 58;
  localparam int SH      = SCALE_FRAC - SPEED_FRAC_BITS;
  localparam logic [PROD_W-1:0] RND = PROD_W'((64'd1 << SH) >> 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_RND    = 4'd2;
  localparam logic [3:0] S_INS    = 4'd3;
  localparam logic [3:0] S_SUM    = 4'd4;
  localparam logic [3:0] S_SUMW   = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_MUL1   = 4'd8;
  localparam logic [3:0] S_MUL2   = 4'd9;
  localparam logic [3:0] S_FILT   = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;

  // Configuration registers
  logic [PERIOD_W-1:0] sample_period;
  logic [SCALE_W-1:0]  speed_scale;
  logic [KEEP_W-1:0]   filter_keep;

  // Control state
  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [PERIOD_W-1:0] tick_count;
  logic [AW-1:0]       fill;
  logic [AW-1:0]       k;
  logic [AW-1:0]       sidx;
  logic                acc_vld;
  logic signed [31:0]  last_position;
  speed_t              filter_output;

  // Datapath registers
  logic signed [31:0]       diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] p1;
  speed_t                   sample;
  logic signed [SUM_W-1:0]  sum;
  logic                     sum_neg;
  speed_t                   avg;

  // Combinational helpers
  logic                     accept;
  logic                     sample_tick;
  logic [KEEP_W-1:0]        keep_eff;
  logic [KEEP_W-1:0]        weight_new;
  logic signed [31:0]       mul_a;
  logic [24:0]              mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [PROD_W-1:0] rnd_shift;
  logic signed [PROD_W-1:0] facc;
  logic signed [PROD_W-1:0] fshift;
  logic                     ins_done;
  logic                     ins_shift;
  logic                     emit_load;
  logic [SUM_W-1:0]         mag;
  logic [SUM_W-1:0]         dividend;
  logic [SUM_W-1:0]         div_quo;
  logic [63:0]              q64;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  assign cfg_ready   = 1'b1;
  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign sample_tick = (tick_count == sample_period);
  assign emit_load   = (state == S_EMIT) && (!out_valid || out_ready);

  // Clamp the keep weight to one
  assign keep_eff   = (filter_keep > ONE_Q16) ? ONE_Q16 : filter_keep;
  assign weight_new = ONE_Q16 - keep_eff;

  // Shared multiplier: sample scaling, then the two filter terms
  always_comb begin
    case (state)
      S_MUL: begin
        mul_a = diff;
        mul_b = {1'b0, speed_scale};
      end
      S_MUL1: begin
        mul_a = filter_output;
        mul_b = 25'(keep_eff);
      end
      default: begin
        mul_a = avg;
        mul_b = 25'(weight_new);
      end
    endcase
  end
  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // Round the scaled sample half up, then drop fraction bits
  assign rnd_sum   = prod + $signed(RND);
  assign rnd_shift = rnd_sum >>> SH;

  // Filter blend with round to nearest
  assign facc   = p1 + prod + 58'sd32768;
  assign fshift = facc >>> SCALE_FRAC;

  // Insert step: shift the larger neighbor up or drop the sample in place
  assign ins_shift = (k != '0) && ($signed(ram_rdata) > sample);
  assign ins_done  = (state == S_INS) && !ins_shift;

  // Magnitude of the sum with half the divisor for rounding
  assign mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign dividend = mag + SUM_W'(KEPT / 2);
  assign q64      = 64'(div_quo);
  assign div_req.start = (state == S_DSTART);

  // RAM addressing per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k;
    ram_wdata = sample;
    ram_raddr = '0;
    case (state)
      S_RND: begin
        ram_raddr = (fill == '0) ? '0 : fill - AW'(1);
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_wdata = ins_shift ? ram_rdata : sample;
        ram_raddr = (k < AW'(2)) ? '0 : k - AW'(2);
      end
      S_SUM: begin
        ram_raddr = sidx;
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && sample_tick) begin
          state_next = S_MUL;
        end
      end
      S_MUL:    state_next = S_RND;
      S_RND:    state_next = S_INS;
      S_INS: begin
        if (ins_done) begin
          state_next = (fill == AW'(WINDOW_SIZE - 1)) ? S_SUM : S_IDLE;
        end
      end
      S_SUM: begin
        if (sidx == AW'(HI)) begin
          state_next = S_SUMW;
        end
      end
      S_SUMW:   state_next = S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_MUL1;
        end
      end
      S_MUL1:   state_next = S_MUL2;
      S_MUL2:   state_next = S_FILT;
      S_FILT:   state_next = S_EMIT;
      S_EMIT: begin
        if (emit_load) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= PERIOD_W'(50);
      speed_scale   <= SCALE_W'(65536);
      filter_keep   <= KEEP_W'(34079);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_PERIOD: sample_period <= cfg_data[PERIOD_W-1:0];
        REG_SPEED_SCALE:   speed_scale   <= cfg_data[SCALE_W-1:0];
        REG_FILTER_KEEP:   filter_keep   <= cfg_data[KEEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tick_count    <= '0;
      fill          <= '0;
      k             <= '0;
      sidx          <= '0;
      acc_vld       <= 1'b0;
      last_position <= '0;
      filter_output <= '0;
      out_valid     <= 1'b0;
    end else begin
      state   <= state_next;
      acc_vld <= (state == S_SUM);
      // Tick counter and position capture
      if (accept) begin
        if (sample_tick) begin
          tick_count    <= PERIOD_W'(1);
          last_position <= encoder_position;
        end else begin
          tick_count <= tick_count + PERIOD_W'(1);
        end
      end
      // Insert loop index
      if (state == S_RND) begin
        k <= fill;
      end else if (state == S_INS && ins_shift) begin
        k <= k - AW'(1);
      end
      // Window fill and trimmed-sum index
      if (ins_done) begin
        if (fill == AW'(WINDOW_SIZE - 1)) begin
          fill <= '0;
          sidx <= AW'(LO);
        end else begin
          fill <= fill + AW'(1);
        end
      end else if (state == S_SUM) begin
        sidx <= sidx + AW'(1);
      end
      // Filter state
      if (state == S_FILT) begin
        filter_output <= sat32(64'(fshift));
      end
      // Output register
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept && sample_tick) begin
      diff <= encoder_position - last_position;
    end
    if (state == S_MUL || state == S_MUL1 || state == S_MUL2) begin
      prod <= mul_p;
    end
    if (state == S_MUL2) begin
      p1 <= prod;
    end
    if (state == S_RND) begin
      sample <= sat32(64'(rnd_shift));
    end
    // Accumulate the kept entries
    if (ins_done) begin
      sum <= '0;
    end else if (acc_vld) begin
      sum <= sum + SUM_W'($signed(ram_rdata));
    end
    if (state == S_DSTART) begin
      sum_neg <= sum[SUM_W-1];
    end
    if (state == S_DIV && div_rsp.done) begin
      avg <= sum_neg ? sat32(-$signed(q64)) : sat32($signed(q64));
    end
    if (emit_load) begin
      filtered_speed <= filter_output;
    end
  end

  etmf_ram #(
    .WIDTH (32),
    .DEPTH (WINDOW_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  etmf_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR    (KEPT)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (dividend),
    .rsp      (div_rsp),
    .quotient (div_quo)
  );

  // The window never holds a full count between items
  assert property (@(posedge clk) disable iff (rst) fill <= AW'(WINDOW_SIZE - 1))
    else $error("window fill out of range");

  // Insert index never passes the fill point
  assert property (@(posedge clk) disable iff (rst) (state == S_INS) |-> (k <= fill))
    else $error("insert index beyond fill");

  // A result appears only from the emit step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EMIT))
    else $error("output raised outside emit");

  // Divider finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst) div_rsp.done |-> (state == S_DIV))
    else $error("divider done out of sequence");

  // No new item while a window is being reduced
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM || state == S_DIV) |-> !in_ready)
    else $error("input open during reduction");

endmodule
